// File: rtl/npg_pkg.sv
// Shared types and constants for the note preview gate sequencer.
// Depends on nothing; used by every other file of the block.
package npg_pkg;

    // Width of the note counts, enough for the largest chord size.
    localparam int CNT_W = 5;
    localparam int BANK_W = 2;
    localparam int PITCH_W = 7;
    localparam int LEVEL_W = 16;
    localparam int LEN_W = 16;
    localparam int TMO_W = 25;
    localparam int FLUSH_W = 24;

    localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'h8000;
    localparam logic [FLUSH_W-1:0] FLUSH_RESET = 24'd88200;
    // Banks 0, 1 and 2 sum to this; the free bank is it minus the two in use.
    localparam logic [BANK_W-1:0] BANK_SUM = 2'd3;

    typedef enum logic [1:0] {
        OP_CHORD = 2'd0,
        OP_END   = 2'd1,
        OP_BLOCK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        K_NOTE = 2'd0,
        K_DONE = 2'd1,
        K_EOS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        M_WAIT   = 3'd0,
        M_START  = 3'd1,
        M_CHANGE = 3'd2,
        M_ACTIVE = 3'd3,
        M_END    = 3'd4,
        M_FLUSH  = 3'd5,
        M_EOS    = 3'd6
    } t_mode;

    typedef enum logic {
        SQ_IDLE = 1'b0,
        SQ_RUN  = 1'b1
    } t_seq_state;

    // Block command handed from the gate control to the event sequencer.
    typedef struct packed {
        logic               start;
        logic               eos;
        logic [BANK_W-1:0]  bank_a;
        logic [CNT_W-1:0]   cnt_a;
        logic [BANK_W-1:0]  bank_q;
        logic [CNT_W-1:0]   cnt_q;
        logic [LEVEL_W-1:0] level;
        logic [LEN_W-1:0]   len;
    } t_blk_cmd;

endpackage

// File: rtl/npg_if.sv
// Request and result channel interfaces, valid/ready handshake.
// Depends on npg_pkg for field widths.
interface npg_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [npg_pkg::PITCH_W-1:0]   pitch;
    logic                          chord_last;
    logic signed [npg_pkg::TMO_W-1:0] timeout_samples;
    logic [npg_pkg::LEVEL_W-1:0]   level;
    logic [npg_pkg::LEN_W-1:0]     block_samples;

    modport source (output valid, op, pitch, chord_last, timeout_samples, level,
                    block_samples, input ready);
    modport sink (input valid, op, pitch, chord_last, timeout_samples, level,
                  block_samples, output ready);
endinterface

interface npg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [npg_pkg::PITCH_W-1:0] event_pitch;
    logic [npg_pkg::LEVEL_W-1:0] event_level;
    logic [npg_pkg::LEN_W-1:0]   block_length;
    logic                        last;

    modport source (output valid, kind, event_pitch, event_level, block_length, last,
                    input ready);
    modport sink (input valid, kind, event_pitch, event_level, block_length, last,
                  output ready);
endinterface

// File: rtl/note_preview_gate_sequencer.sv
// Top level of the note preview gate: mode and timeout control, chord bank
// bookkeeping. Uses npg_pkg, npg_if, npg_note_mem and npg_emit.
//
// Channel   Dir  Handshake        Carries
// i_req     in   valid/ready      op, pitch, chord_last, timeout_samples, level,
//                                 block_samples
// o_rsp     out  valid/ready      kind, event_pitch, event_level, block_length, last
// i_flush   in   write enable     flush_samples (24 bit), no read-back
//
// Chord and end requests give no result.
// A block request gives one result per note event and a final one; the single
// read port of the note memory sets one event per cycle when no stall holds it.
// Synchronous active-low reset; the note memory needs no clearing pass.
// No request is taken while a block runs; a stalled consumer holds each event
// in the output register and stretches the block by the length of the stall.
module note_preview_gate_sequencer #(
    parameter int MAX_NOTES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_flush_we,
    input  logic [npg_pkg::FLUSH_W-1:0]   i_flush_data,
    npg_req_if.sink                       i_req,
    npg_rsp_if.source                     o_rsp
);

    // Index width of one bank; at least one bit so a bank is addressable.
    localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW = npg_pkg::CNT_W;
    localparam int TW = npg_pkg::TMO_W;

    // Gate state. Three memory banks hold the staged, queued and active
    // chords; copying a chord is a swap of bank pointers.
    npg_pkg::t_mode                  r_mode, n_mode;
    logic signed [TW-1:0]            r_tl, n_tl;
    logic [CW-1:0]                   r_cnt_s, n_cnt_s;
    logic [CW-1:0]                   r_cnt_q, n_cnt_q;
    logic [CW-1:0]                   r_cnt_a, n_cnt_a;
    logic [npg_pkg::BANK_W-1:0]      r_bank_s, n_bank_s;
    logic [npg_pkg::BANK_W-1:0]      r_bank_q, n_bank_q;
    logic [npg_pkg::BANK_W-1:0]      r_bank_a, n_bank_a;
    logic [npg_pkg::LEVEL_W-1:0]     r_level, n_level;
    logic [npg_pkg::FLUSH_W-1:0]     r_flush;

    logic                            acc, idle, room;
    logic                            mem_we, mem_re;
    logic [npg_pkg::BANK_W+IW-1:0]   mem_waddr, mem_raddr;
    logic [npg_pkg::PITCH_W-1:0]     mem_rdata;
    logic signed [TW-1:0]            tl_base, tl_dec;
    npg_pkg::t_mode                  blk_mode;
    npg_pkg::t_blk_cmd               cmd;

    // Requests are taken only out of reset and while the sequencer is between
    // blocks, so memory writes never overlap the reads of a block.
    assign i_req.ready = idle && i_rst_n;
    assign acc         = i_req.valid && i_req.ready;
    assign room        = r_cnt_s < CW'(MAX_NOTES);

    assign mem_we    = acc && (i_req.op == npg_pkg::OP_CHORD) && room;
    assign mem_waddr = {r_bank_s, r_cnt_s[IW-1:0]};

    // Block-time mode and timeout: the copy to active or the start of the
    // flush happens first, then the countdown by the block length.
    always_comb begin
        blk_mode = r_mode;
        tl_base  = r_tl;
        case (r_mode)
            npg_pkg::M_START, npg_pkg::M_CHANGE: blk_mode = npg_pkg::M_ACTIVE;
            npg_pkg::M_END: begin
                blk_mode = npg_pkg::M_FLUSH;
                tl_base  = TW'(r_flush);
            end
            default: ;
        endcase
        tl_dec = tl_base - TW'(i_req.block_samples);
    end

    always_comb begin
        n_mode   = r_mode;
        n_tl     = r_tl;
        n_cnt_s  = r_cnt_s;
        n_cnt_q  = r_cnt_q;
        n_cnt_a  = r_cnt_a;
        n_bank_s = r_bank_s;
        n_bank_q = r_bank_q;
        n_bank_a = r_bank_a;
        n_level  = r_level;
        if (acc) begin
            case (i_req.op)
                npg_pkg::OP_CHORD: begin
                    if (room) begin
                        n_cnt_s = r_cnt_s + 1'b1;
                    end
                    if (i_req.chord_last) begin
                        // Staged bank becomes queued; staging moves to the
                        // bank that is neither queued nor active.
                        n_bank_q = r_bank_s;
                        n_bank_s = npg_pkg::BANK_SUM - r_bank_s - r_bank_a;
                        n_cnt_q  = room ? r_cnt_s + 1'b1 : r_cnt_s;
                        n_cnt_s  = '0;
                        n_tl     = i_req.timeout_samples[TW-1] ? '1 : i_req.timeout_samples;
                        n_level  = (i_req.level > npg_pkg::ONE_Q15) ? npg_pkg::ONE_Q15
                                                                   : i_req.level;
                        case (r_mode)
                            npg_pkg::M_WAIT, npg_pkg::M_EOS, npg_pkg::M_FLUSH,
                            npg_pkg::M_START:
                                n_mode = npg_pkg::M_START;
                            default: n_mode = npg_pkg::M_CHANGE;
                        endcase
                    end
                end
                npg_pkg::OP_END: begin
                    case (r_mode)
                        npg_pkg::M_START: n_mode = npg_pkg::M_WAIT;
                        npg_pkg::M_ACTIVE, npg_pkg::M_CHANGE: n_mode = npg_pkg::M_END;
                        default: ;
                    endcase
                end
                npg_pkg::OP_BLOCK: begin
                    if (r_mode != npg_pkg::M_EOS) begin
                        if (r_mode == npg_pkg::M_START || r_mode == npg_pkg::M_CHANGE) begin
                            n_bank_a = r_bank_q;
                            n_cnt_a  = r_cnt_q;
                        end
                        n_mode = blk_mode;
                        n_tl   = tl_base;
                        if (!tl_base[TW-1]) begin
                            n_tl = tl_dec;
                            if (tl_dec[TW-1]) begin
                                if (blk_mode == npg_pkg::M_ACTIVE) begin
                                    n_mode = npg_pkg::M_END;
                                end else if (blk_mode == npg_pkg::M_FLUSH) begin
                                    n_mode = npg_pkg::M_EOS;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Block command: note-offs from the old active chord, then note-ons
    // from the queued chord, both read from the banks as they stand now.
    always_comb begin
        cmd        = '0;
        cmd.start  = acc && (i_req.op == npg_pkg::OP_BLOCK);
        cmd.eos    = r_mode == npg_pkg::M_EOS;
        cmd.bank_a = r_bank_a;
        cmd.bank_q = r_bank_q;
        cmd.level  = r_level;
        cmd.len    = i_req.block_samples;
        if (r_mode == npg_pkg::M_CHANGE || r_mode == npg_pkg::M_END) begin
            cmd.cnt_a = r_cnt_a;
        end
        if (r_mode == npg_pkg::M_START || r_mode == npg_pkg::M_CHANGE) begin
            cmd.cnt_q = r_cnt_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= npg_pkg::M_EOS;
            r_tl     <= '1;
            r_cnt_s  <= '0;
            r_cnt_q  <= '0;
            r_cnt_a  <= '0;
            r_bank_s <= npg_pkg::BANK_W'(0);
            r_bank_q <= npg_pkg::BANK_W'(1);
            r_bank_a <= npg_pkg::BANK_W'(2);
            r_level  <= npg_pkg::ONE_Q15;
            r_flush  <= npg_pkg::FLUSH_RESET;
        end else begin
            r_mode   <= n_mode;
            r_tl     <= n_tl;
            r_cnt_s  <= n_cnt_s;
            r_cnt_q  <= n_cnt_q;
            r_cnt_a  <= n_cnt_a;
            r_bank_s <= n_bank_s;
            r_bank_q <= n_bank_q;
            r_bank_a <= n_bank_a;
            r_level  <= n_level;
            if (i_flush_we) begin
                r_flush <= i_flush_data;
            end
        end
    end

    npg_note_mem #(
        .IW (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_req.pitch),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    npg_emit #(
        .IW (IW)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_idle  (idle),
        .o_re    (mem_re),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata),
        .o_rsp   (o_rsp)
    );

    a_bank_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank_s != r_bank_q && r_bank_s != r_bank_a)
        else $error("staging bank shared with a live chord");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_s <= CW'(MAX_NOTES) && r_cnt_q <= CW'(MAX_NOTES)
            && r_cnt_a <= CW'(MAX_NOTES))
        else $error("note count above chord size");

    a_eos_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_req.op == npg_pkg::OP_BLOCK && r_mode == npg_pkg::M_EOS
            |=> r_mode == npg_pkg::M_EOS && $stable(r_tl))
        else $error("block in end of stream changed the gate");

endmodule

// File: rtl/npg_note_mem.sv
// Note store: three banks of pitches in one synchronous memory.
// One write port, one read port with registered read data. Uses npg_pkg.
module npg_note_mem #(
    parameter int IW = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [npg_pkg::BANK_W+IW-1:0]         i_waddr,
    input  logic [npg_pkg::PITCH_W-1:0]           i_wdata,
    input  logic                                  i_re,
    input  logic [npg_pkg::BANK_W+IW-1:0]         i_raddr,
    output logic [npg_pkg::PITCH_W-1:0]           o_rdata
);

    localparam int DEPTH = 3 * (1 << IW);

    logic [npg_pkg::PITCH_W-1:0] r_mem [DEPTH];
    logic [npg_pkg::PITCH_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/npg_emit.sv
// Event sequencer: walks the note-off and note-on lists of one block through
// the note memory and drives the result register. Uses npg_pkg, npg_rsp_if.
module npg_emit #(
    parameter int IW = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  npg_pkg::t_blk_cmd                 i_cmd,
    output logic                              o_idle,
    output logic                              o_re,
    output logic [npg_pkg::BANK_W+IW-1:0]     o_raddr,
    input  logic [npg_pkg::PITCH_W-1:0]       i_rdata,
    npg_rsp_if.source                         o_rsp
);

    localparam int TW = npg_pkg::CNT_W + 1;

    npg_pkg::t_seq_state r_st, n_st;

    logic [TW-1:0]                  r_idx, r_tot;
    logic [npg_pkg::CNT_W-1:0]      r_cnt_a;
    logic [npg_pkg::BANK_W-1:0]     r_bank_a, r_bank_q;
    logic [npg_pkg::LEVEL_W-1:0]    r_level;
    logic [npg_pkg::LEN_W-1:0]      r_len;
    logic                           r_eos;
    logic                           r_pend, r_pend_on;

    logic                           r_ovalid, r_olast;
    logic [1:0]                     r_okind;
    logic [npg_pkg::PITCH_W-1:0]    r_opitch;
    logic [npg_pkg::LEVEL_W-1:0]    r_olevel;
    logic [npg_pkg::LEN_W-1:0]      r_olen;

    logic            run, more, in_a, out_free, load_note, load_final, issue;
    logic [TW-1:0]   idx_sel;

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            npg_pkg::SQ_IDLE: begin
                if (i_cmd.start) begin
                    n_st = npg_pkg::SQ_RUN;
                end
            end
            npg_pkg::SQ_RUN: begin
                if (load_final) begin
                    n_st = npg_pkg::SQ_IDLE;
                end
            end
            default: n_st = npg_pkg::SQ_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        case (r_st)
            npg_pkg::SQ_IDLE: begin
                o_idle = 1'b1;
                run    = 1'b0;
            end
            npg_pkg::SQ_RUN: begin
                o_idle = 1'b0;
                run    = 1'b1;
            end
            default: begin
                o_idle = 1'b0;
                run    = 1'b0;
            end
        endcase
    end

    // Read pipeline: a read is issued when its data will have a free slot.
    always_comb begin
        out_free   = !r_ovalid || o_rsp.ready;
        more       = r_idx < r_tot;
        in_a       = r_idx < TW'(r_cnt_a);
        load_note  = run && r_pend && out_free;
        issue      = run && more && (!r_pend || load_note);
        load_final = run && !more && !r_pend && out_free;
        idx_sel    = in_a ? r_idx : r_idx - TW'(r_cnt_a);
    end

    assign o_re    = issue;
    assign o_raddr = {(in_a ? r_bank_a : r_bank_q), idx_sel[IW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= npg_pkg::SQ_IDLE;
            r_pend <= 1'b0;
        end else begin
            r_st <= n_st;
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load_note) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!run && i_cmd.start) begin
            r_idx    <= '0;
            r_tot    <= TW'(i_cmd.cnt_a) + TW'(i_cmd.cnt_q);
            r_cnt_a  <= i_cmd.cnt_a;
            r_bank_a <= i_cmd.bank_a;
            r_bank_q <= i_cmd.bank_q;
            r_level  <= i_cmd.level;
            r_len    <= i_cmd.len;
            r_eos    <= i_cmd.eos;
        end else if (issue) begin
            r_idx     <= r_idx + 1'b1;
            r_pend_on <= !in_a;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_note || load_final) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_note) begin
            r_okind  <= npg_pkg::K_NOTE;
            r_opitch <= i_rdata;
            r_olevel <= r_pend_on ? r_level : '0;
            r_olen   <= '0;
            r_olast  <= 1'b0;
        end else if (load_final) begin
            r_okind  <= r_eos ? npg_pkg::K_EOS : npg_pkg::K_DONE;
            r_opitch <= '0;
            r_olevel <= '0;
            r_olen   <= r_eos ? '0 : r_len;
            r_olast  <= 1'b1;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.kind         = r_okind;
    assign o_rsp.event_pitch  = r_opitch;
    assign o_rsp.event_level  = r_olevel;
    assign o_rsp.block_length = r_olen;
    assign o_rsp.last         = r_olast;

    a_pend_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_st == npg_pkg::SQ_RUN)
        else $error("read data pending outside a block");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == npg_pkg::SQ_RUN |-> r_idx <= r_tot)
        else $error("read index ran past the event count");

    a_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == npg_pkg::SQ_RUN) ##1 (r_st == npg_pkg::SQ_IDLE)
            |-> r_ovalid && r_olast)
        else $error("block finished without a final result");

endmodule

// File: sim/tb.sv
// Testbench for note_preview_gate_sequencer: directed and random request streams,
// each result checked in order against a cycle-free model of the gate.
// Depends on npg_pkg, npg_req_if / npg_rsp_if and the RTL top level.
module tb;

    localparam int MAX_NOTES = 16;
    localparam int LIMIT_CYCLES = 1_000_000;
    // Spare cycles after the last result let a trailing chord or end request settle.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_REQUESTS = 200;
    localparam int MAX_PRINTED = 100;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [npg_pkg::TMO_W-1:0] NO_TIMEOUT = 25'h1FFFFFF;
    localparam logic [npg_pkg::TMO_W-1:0] MAX_TIMEOUT = 25'h0FFFFFF;
    localparam logic [npg_pkg::TMO_W-1:0] MIN_TIMEOUT = 25'h1000000;
    localparam logic [npg_pkg::FLUSH_W-1:0] MAX_FLUSH = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]                  op;
        logic [npg_pkg::PITCH_W-1:0] pitch;
        logic                        chord_last;
        logic [npg_pkg::TMO_W-1:0]   tmo;
        logic [npg_pkg::LEVEL_W-1:0] level;
        logic [npg_pkg::LEN_W-1:0]   len;
    } t_req;

    typedef struct packed {
        npg_pkg::t_kind              kind;
        logic [npg_pkg::PITCH_W-1:0] pitch;
        logic [npg_pkg::LEVEL_W-1:0] level;
        logic [npg_pkg::LEN_W-1:0]   len;
        logic                        last;
    } t_event;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_flush_we;
    logic [npg_pkg::FLUSH_W-1:0] i_flush_data;

    npg_req_if req_ch ();
    npg_rsp_if rsp_ch ();

    note_preview_gate_sequencer #(
        .MAX_NOTES(MAX_NOTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flush_we  (i_flush_we),
        .i_flush_data(i_flush_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Gate model state
    npg_pkg::t_mode              gate_mode;
    int                          timeout_left;
    logic [npg_pkg::PITCH_W-1:0] active_pitch [MAX_NOTES];
    logic [npg_pkg::PITCH_W-1:0] queued_pitch [MAX_NOTES];
    logic [npg_pkg::PITCH_W-1:0] staged_pitch [MAX_NOTES];
    int                          active_cnt;
    int                          queued_cnt;
    int                          staged_cnt;
    logic [npg_pkg::LEVEL_W-1:0] held_level;
    logic [npg_pkg::FLUSH_W-1:0] flush_len;

    t_event pending_events [$];
    t_event want;

    int  errors;
    int  cycle_count;
    int  requests_sent;
    int  results_checked;
    int  flush_settings;
    int  sessions;
    bit  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_events.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch (cycle %0d, result %0d): %s", cycle_count, results_checked, msg);
    endtask

    // ---------------------------------------------------------------
    // Model
    // ---------------------------------------------------------------
    function automatic void reset_gate_model();
        gate_mode = npg_pkg::M_EOS;
        timeout_left = -1;
        active_cnt = 0;
        queued_cnt = 0;
        staged_cnt = 0;
        held_level = npg_pkg::ONE_Q15;
        flush_len = npg_pkg::FLUSH_RESET;
        for (int i = 0; i < MAX_NOTES; i++) begin
            active_pitch[i] = '0;
            queued_pitch[i] = '0;
            staged_pitch[i] = '0;
        end
    endfunction

    function automatic void expect_event(input npg_pkg::t_kind k,
                                         input logic [npg_pkg::PITCH_W-1:0] p,
                                         input logic [npg_pkg::LEVEL_W-1:0] lv,
                                         input logic [npg_pkg::LEN_W-1:0] n,
                                         input logic lst);
        t_event ev;
        ev.kind = k;
        ev.pitch = p;
        ev.level = lv;
        ev.len = n;
        ev.last = lst;
        pending_events.push_back(ev);
    endfunction

    function automatic void gate_predict(input t_req r);
        if (r.op == npg_pkg::OP_CHORD) begin
            // pitches past the chord limit are dropped, the commit still happens
            if (staged_cnt < MAX_NOTES) begin
                staged_pitch[staged_cnt] = r.pitch;
                staged_cnt++;
            end
            if (r.chord_last) begin
                queued_pitch = staged_pitch;
                queued_cnt = staged_cnt;
                staged_cnt = 0;
                timeout_left = r.tmo[npg_pkg::TMO_W-1] ? -1
                                                       : int'(r.tmo[npg_pkg::TMO_W-2:0]);
                held_level = (r.level > npg_pkg::ONE_Q15) ? npg_pkg::ONE_Q15 : r.level;
                if (gate_mode == npg_pkg::M_WAIT || gate_mode == npg_pkg::M_EOS
                    || gate_mode == npg_pkg::M_FLUSH)
                    gate_mode = npg_pkg::M_START;
                else if (gate_mode == npg_pkg::M_END || gate_mode == npg_pkg::M_ACTIVE
                         || gate_mode == npg_pkg::M_CHANGE)
                    gate_mode = npg_pkg::M_CHANGE;
            end
        end else if (r.op == npg_pkg::OP_END) begin
            if (gate_mode == npg_pkg::M_START)
                gate_mode = npg_pkg::M_WAIT;
            else if (gate_mode == npg_pkg::M_ACTIVE || gate_mode == npg_pkg::M_CHANGE)
                gate_mode = npg_pkg::M_END;
        end else if (r.op == npg_pkg::OP_BLOCK) begin
            if (gate_mode == npg_pkg::M_EOS) begin
                expect_event(npg_pkg::K_EOS, '0, '0, '0, 1'b1);
            end else begin
                if (gate_mode == npg_pkg::M_START || gate_mode == npg_pkg::M_CHANGE) begin
                    if (gate_mode == npg_pkg::M_CHANGE)
                        for (int i = 0; i < active_cnt; i++)
                            expect_event(npg_pkg::K_NOTE, active_pitch[i], '0, '0, 1'b0);
                    for (int i = 0; i < queued_cnt; i++)
                        expect_event(npg_pkg::K_NOTE, queued_pitch[i], held_level, '0, 1'b0);
                    active_pitch = queued_pitch;
                    active_cnt = queued_cnt;
                    gate_mode = npg_pkg::M_ACTIVE;
                end else if (gate_mode == npg_pkg::M_END) begin
                    for (int i = 0; i < active_cnt; i++)
                        expect_event(npg_pkg::K_NOTE, active_pitch[i], '0, '0, 1'b0);
                    gate_mode = npg_pkg::M_FLUSH;
                    timeout_left = int'(flush_len);
                end
                if (timeout_left >= 0) begin
                    timeout_left -= int'(r.len);
                    if (timeout_left < 0) begin
                        if (gate_mode == npg_pkg::M_ACTIVE)
                            gate_mode = npg_pkg::M_END;
                        else if (gate_mode == npg_pkg::M_FLUSH)
                            gate_mode = npg_pkg::M_EOS;
                    end
                end
                expect_event(npg_pkg::K_DONE, '0, '0, r.len, 1'b1);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stalls, in-order check
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (no_idle || $urandom_range(0, 3) != 0) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d pitch %0d",
                                          rsp_ch.kind, rsp_ch.event_pitch));
            end else begin
                want = pending_events.pop_front();
                if (rsp_ch.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", rsp_ch.kind, want.kind));
                if (rsp_ch.event_pitch !== want.pitch)
                    report_mismatch($sformatf("event_pitch %0d, want %0d",
                                              rsp_ch.event_pitch, want.pitch));
                if (rsp_ch.event_level !== want.level)
                    report_mismatch($sformatf("event_level %0d, want %0d",
                                              rsp_ch.event_level, want.level));
                if (rsp_ch.block_length !== want.len)
                    report_mismatch($sformatf("block_length %0d, want %0d",
                                              rsp_ch.block_length, want.len));
                if (rsp_ch.last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", rsp_ch.last, want.last));
            end
            results_checked++;
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // Called at a clock edge; returns at the edge the request is taken, with
    // valid still high so a back-to-back request needs no second assignment.
    task automatic send_request(input t_req r);
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            req_ch.valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        req_ch.op <= r.op;
        req_ch.pitch <= r.pitch;
        req_ch.chord_last <= r.chord_last;
        req_ch.timeout_samples <= r.tmo;
        req_ch.level <= r.level;
        req_ch.block_samples <= r.len;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        gate_predict(r);
        if (r.op != OP_NONE)
            requests_sent++;
    endtask

    // Sender holds off until every pending result is in, then lets the block settle.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_flush(input logic [npg_pkg::FLUSH_W-1:0] v);
        i_flush_we <= 1'b1;
        i_flush_data <= v;
        @(posedge i_clk);
        i_flush_we <= 1'b0;
        flush_len = v;
        flush_settings++;
    endtask

    task automatic send_chord_element(input logic [npg_pkg::PITCH_W-1:0] p, input logic lst,
                                      input logic [npg_pkg::TMO_W-1:0] tmo,
                                      input logic [npg_pkg::LEVEL_W-1:0] lv);
        send_request('{op: npg_pkg::OP_CHORD, pitch: p, chord_last: lst, tmo: tmo,
                       level: lv, len: 16'($urandom)});
    endtask

    task automatic send_block(input logic [npg_pkg::LEN_W-1:0] n);
        send_request('{op: npg_pkg::OP_BLOCK, pitch: 7'($urandom), chord_last: 1'($urandom),
                       tmo: 25'($urandom), level: 16'($urandom), len: n});
    endtask

    task automatic send_end();
        send_request('{op: npg_pkg::OP_END, pitch: 7'($urandom), chord_last: 1'($urandom),
                       tmo: 25'($urandom), level: 16'($urandom), len: 16'($urandom)});
    endtask

    task automatic send_noise();
        send_request('{op: OP_NONE, pitch: 7'($urandom), chord_last: 1'($urandom),
                       tmo: 25'($urandom), level: 16'($urandom), len: 16'($urandom)});
    endtask

    function automatic logic [npg_pkg::TMO_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) return NO_TIMEOUT;
        if (r < 4) return {1'b1, 24'($urandom)};
        if (r == 4) return MAX_TIMEOUT;
        return 25'($urandom_range(0, 1200));
    endfunction

    function automatic logic [npg_pkg::LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom_range(32769, 65535));
        if (r == 1) return npg_pkg::ONE_Q15;
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic logic [npg_pkg::LEN_W-1:0] pick_block_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'($urandom);
        return 16'($urandom_range(0, 400));
    endfunction

    function automatic logic [npg_pkg::FLUSH_W-1:0] pick_flush();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return MAX_FLUSH;
        return 24'($urandom_range(0, 1500));
    endfunction

    task automatic send_chord(input int n);
        for (int i = 0; i < n; i++)
            send_chord_element(7'($urandom), i == n - 1, pick_timeout(), pick_level());
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Straight out of reset the gate sits at end of stream.
    task automatic test_end_of_stream();
        send_block(16'hFFFF);
        send_end();
        send_noise();
        send_block(16'h0000);
    endtask

    // 17 pitches with the commit on the dropped one; level saturates.
    task automatic test_chord_overflow();
        wait_for_results();
        write_flush('0);
        no_idle = 1'b1;
        for (int i = 0; i < MAX_NOTES; i++)
            send_chord_element((i == MAX_NOTES - 1) ? 7'd127 : 7'(i * 8), 1'b0,
                               NO_TIMEOUT, '0);
        send_chord_element(7'd99, 1'b1, MAX_TIMEOUT, 16'hFFFF);
        send_block(16'h0000);
        no_idle = 1'b0;
    endtask

    // Chord change while active, then end, zero flush straight to end of stream.
    task automatic test_change_and_end();
        send_chord_element(7'd0, 1'b1, NO_TIMEOUT, npg_pkg::ONE_Q15);
        send_block(16'hFFFF);
        send_end();
        send_block(16'd1);
        send_block(16'd7);
    endtask

    // Restart while starting, end from start mode, timeout expiry, ends ignored in flush.
    task automatic test_start_while_starting();
        wait_for_results();
        write_flush(MAX_FLUSH);
        send_chord_element(7'd127, 1'b1, '0, 16'd1);
        send_chord_element(7'd5, 1'b0, '0, '0);
        send_chord_element(7'd6, 1'b1, MIN_TIMEOUT, npg_pkg::ONE_Q15);
        send_end();
        send_chord_element(7'd9, 1'b1, 25'd3, 16'h5555);
        send_block(16'd2);
        send_block(16'd2);
        send_block(16'd0);
        send_end();
        send_block(16'hAAAA);
    endtask

    // Mostly well-formed sessions: a chord, then blocks mixed with ends,
    // chord changes, stray elements and ignored opcodes.
    task automatic run_session();
        int notes;
        int steps;
        int pick;
        if ($urandom_range(0, 14) == 0)
            notes = $urandom_range(MAX_NOTES + 1, MAX_NOTES + 4);
        else
            notes = $urandom_range(1, 6);
        send_chord(notes);
        steps = $urandom_range(1, 8);
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                send_block(pick_block_len());
            else if (pick < 74)
                send_end();
            else if (pick < 86)
                send_chord($urandom_range(1, 5));
            else if (pick < 92)
                send_chord_element(7'($urandom), 1'b0, pick_timeout(), pick_level());
            else
                send_noise();
        end
    endtask

    task automatic test_random_sessions();
        int start;
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 9) == 0) begin
                wait_for_results();
                write_flush(pick_flush());
            end else if ($urandom_range(0, 19) == 0) begin
                wait_for_results();
            end
            no_idle = ($urandom_range(0, 7) == 0);
            run_session();
            sessions++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors = 0;
        cycle_count = 0;
        requests_sent = 0;
        results_checked = 0;
        flush_settings = 0;
        sessions = 0;
        no_idle = 1'b0;
        reset_gate_model();
        i_rst_n <= 1'b0;
        i_flush_we <= 1'b0;
        i_flush_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.op <= npg_pkg::OP_BLOCK;
        req_ch.pitch <= '0;
        req_ch.chord_last <= 1'b0;
        req_ch.timeout_samples <= '0;
        req_ch.level <= '0;
        req_ch.block_samples <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_end_of_stream();
        test_chord_overflow();
        test_change_and_end();
        test_start_while_starting();
        test_random_sessions();

        wait_for_results();
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_events.size()));

        $display("tb: %0d requests (%0d random sessions), %0d results checked",
                 requests_sent, sessions, results_checked);
        $display("tb: %0d flush settings, %0d mismatches", flush_settings, errors);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
